/* hdl/quantum_gate_state_update_unit_defines.svh */
// Assertion macros for the gate state update unit
`ifndef QUANTUM_GATE_STATE_UPDATE_UNIT_DEFINES_SVH
`define QUANTUM_GATE_STATE_UPDATE_UNIT_DEFINES_SVH

// implication checked every clock outside reset
`define QG_ASSERT_IMP(label, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define QG_ASSERT_NEXT(label, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/qgsu_pkg.sv */
package qgsu_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_AMP = 2'd0,
        OP_WRITE_MAT = 2'd1,
        OP_APPLY     = 2'd2,
        OP_READ_AMP  = 2'd3
    } op_t;

    localparam logic [1:0] REG_TARGET_COUNT = 2'd0;
    localparam logic [1:0] REG_TARGET_POS_0 = 2'd1;
    localparam logic [1:0] REG_TARGET_POS_1 = 2'd2;
    localparam logic [1:0] REG_TARGET_POS_2 = 2'd3;

    localparam int MaxK = 8;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  index;
        logic signed [15:0] value_real;
        logic signed [15:0] value_imag;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] read_real;
        logic signed [15:0] read_imag;
        logic               index_error;
    } out_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic       start;       // latch input word, decode
        logic       amp_rd;      // read amplitude at gather address
        logic       gather_cap;  // capture read data into gather slot
        logic [2:0] slot;        // gather slot / column / row
        logic [2:0] row;
        logic       acc_clr;
        logic       mac_issue;   // start one complex product term set
        logic       mac_acc;     // accumulate registered products
        logic       wb;          // write back row result
        logic       simple;      // do write or read op
        logic       simple_cap;  // capture read data for read op
    } qg_cmd_t;

    typedef struct packed {
        logic       is_apply;
        logic       err;
        logic [3:0] kk;          // 2**K, rows of the gate matrix
    } qg_status_t;

endpackage

/* hdl/qgsu_ctrl.sv */
module qgsu_ctrl
    import qgsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_go,
    input  qg_status_t status,
    output qg_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SIMPLE, S_SIMPLE_RD, S_SIMPLE_CAP,
        S_G_RD, S_G_CAP, S_ROW, S_MUL, S_ACC, S_WB, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] slot_reg, slot_next;
    logic [2:0] row_reg, row_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        row_next   = row_reg;
        cmd        = '0;
        cmd.slot   = slot_reg;
        cmd.row    = row_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_go)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                slot_next = '0;
                row_next  = '0;
                if (status.err)
                    state_next = S_DONE;
                else if (status.is_apply)
                    state_next = S_G_RD;
                else
                    state_next = S_SIMPLE;
            end
            S_SIMPLE:
            begin
                cmd.simple = 1'b1;
                state_next = S_SIMPLE_RD;
            end
            S_SIMPLE_RD:   state_next = S_SIMPLE_CAP;
            S_SIMPLE_CAP:
            begin
                cmd.simple_cap = 1'b1;
                state_next     = S_DONE;
            end
            S_G_RD:
            begin
                cmd.amp_rd = 1'b1;
                state_next = S_G_CAP;
            end
            S_G_CAP:
            begin
                cmd.gather_cap = 1'b1;
                if ({1'b0, slot_reg} == status.kk - 4'd1)
                begin
                    slot_next  = '0;
                    state_next = S_ROW;
                end
                else
                begin
                    slot_next  = slot_reg + 3'd1;
                    state_next = S_G_RD;
                end
            end
            S_ROW:
            begin
                cmd.acc_clr = 1'b1;
                slot_next   = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mac_issue = 1'b1;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                cmd.mac_acc = 1'b1;
                if ({1'b0, slot_reg} == status.kk - 4'd1)
                    state_next = S_WB;
                else
                begin
                    slot_next  = slot_reg + 3'd1;
                    // fetch the next column's matrix entry
                    cmd.slot   = slot_reg + 3'd1;
                    state_next = S_MUL;
                end
            end
            S_WB:
            begin
                cmd.wb    = 1'b1;
                slot_next = '0;
                if ({1'b0, row_reg} == status.kk - 4'd1)
                    state_next = S_DONE;
                else
                begin
                    row_next   = row_reg + 3'd1;
                    state_next = S_ROW;
                end
            end
            S_DONE:        state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            row_reg   <= row_next;
        end
    end

endmodule

/* hdl/qgsu_datapath.sv */
module qgsu_datapath
    import qgsu_pkg::*;
#(
    parameter int STATE_QUBITS = 10,
    parameter int AMP_WIDTH    = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_word_t   in_word,
    input  logic [1:0] target_count,
    input  logic [3:0] target_pos_0,
    input  logic [3:0] target_pos_1,
    input  logic [3:0] target_pos_2,
    input  logic [1:0] max_k,
    input  qg_cmd_t    cmd,
    output qg_status_t status,
    output out_word_t  result
);

    localparam int AW     = STATE_QUBITS;
    localparam int DEPTH  = 1 << AW;
    localparam int FRAC   = AMP_WIDTH - 2;
    localparam int PW     = 2 * AMP_WIDTH + 1;
    localparam int SW     = AMP_WIDTH + 1;

    localparam logic signed [SW-1:0] AMP_MAX = SW'((1 <<< (AMP_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] AMP_MIN = -AMP_MAX - SW'(1);

    typedef logic signed [AMP_WIDTH-1:0] amp_t;

    // memories
    logic [2*AMP_WIDTH-1:0] amp_mem [DEPTH];
    logic [2*AMP_WIDTH-1:0] mat_mem [64];
    logic [2*AMP_WIDTH-1:0] amp_rd_reg;
    logic [2*AMP_WIDTH-1:0] mat_rd_reg;

    in_word_t   word_reg;
    logic [1:0] k_reg;
    logic [3:0] kk_reg;
    logic       err_reg;
    logic [AW-1:0] base_reg;
    amp_t       gre_reg [MaxK];
    amp_t       gim_reg [MaxK];
    logic signed [SW-1:0] acc_r0_reg, acc_r1_reg, acc_i_reg;
    amp_t       p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    amp_t       rd_re_reg, rd_im_reg;

    function automatic amp_t sat_w(input logic signed [SW:0] v);
        if (v > (SW+1)'(AMP_MAX))
            return AMP_MAX[AMP_WIDTH-1:0];
        else if (v < (SW+1)'(AMP_MIN))
            return AMP_MIN[AMP_WIDTH-1:0];
        else
            return v[AMP_WIDTH-1:0];
    endfunction

    function automatic amp_t fx_mul(input amp_t a, input amp_t b);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = PW'(a * b) + PW'(1 <<< (FRAC - 1));
        q = p >>> FRAC;
        if (q > PW'(AMP_MAX))
            return AMP_MAX[AMP_WIDTH-1:0];
        else if (q < PW'(AMP_MIN))
            return AMP_MIN[AMP_WIDTH-1:0];
        else
            return q[AMP_WIDTH-1:0];
    endfunction

    function automatic amp_t in_sat(input logic signed [15:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w > 32'((1 <<< (AMP_WIDTH - 1)) - 1))
            return AMP_MAX[AMP_WIDTH-1:0];
        else if (w < -32'(1 <<< (AMP_WIDTH - 1)))
            return AMP_MIN[AMP_WIDTH-1:0];
        else
            return w[AMP_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] out_sat(input amp_t v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w > 32'sd32767)
            return 16'h7fff;
        else if (w < -32'sd32768)
            return 16'h8000;
        else
            return w[15:0];
    endfunction

    // insert a zero at position p
    function automatic logic [AW-1:0] ins0(input logic [AW-1:0] v, input logic [3:0] p);
        logic [AW-1:0] lowm;
        lowm = (AW'(1) << p) - AW'(1);
        return ((v & ~lowm) << 1) | (v & lowm);
    endfunction

    // decode of current item
    logic [1:0] k_eff;
    logic [3:0] kk_eff;
    logic       pos_ok, dec_err;
    logic [AW-1:0] base_c;
    logic [10:0] idx_w;
    always_comb
    begin
        k_eff = (target_count == 2'd0) ? 2'd1 : target_count;
        if (k_eff > max_k)
            k_eff = max_k;
        kk_eff = 4'd1 << k_eff;
        idx_w  = {1'b0, word_reg.index};
        pos_ok = ({1'b0, target_pos_0} < 5'(STATE_QUBITS));
        if (k_eff >= 2'd2)
            pos_ok = pos_ok && ({1'b0, target_pos_1} < 5'(STATE_QUBITS))
                     && (target_pos_1 > target_pos_0);
        if (k_eff == 2'd3)
            pos_ok = pos_ok && ({1'b0, target_pos_2} < 5'(STATE_QUBITS))
                     && (target_pos_2 > target_pos_1);
        case (word_reg.operation)
            OP_WRITE_MAT: dec_err = (idx_w >= 11'(kk_eff) * 11'(kk_eff));
            OP_APPLY:     dec_err = !pos_ok ||
                                    (32'(word_reg.index) >= (32'(1) << (AW - k_eff)));
            default:      dec_err = (32'(word_reg.index) >= 32'(DEPTH));
        endcase
        base_c = ins0(AW'(word_reg.index), target_pos_0);
        if (k_eff >= 2'd2)
            base_c = ins0(base_c, target_pos_1);
        if (k_eff == 2'd3)
            base_c = ins0(base_c, target_pos_2);
    end

    // target address for slot s
    function automatic logic [AW-1:0] tgt_addr(input logic [2:0] s);
        logic [AW-1:0] a;
        a = base_reg;
        if (s[0])
            a = a | (AW'(1) << target_pos_0);
        if (s[1] && k_reg >= 2'd2)
            a = a | (AW'(1) << target_pos_1);
        if (s[2] && k_reg == 2'd3)
            a = a | (AW'(1) << target_pos_2);
        return a;
    endfunction

    logic [5:0] mat_addr;
    assign mat_addr = (k_reg == 2'd1) ? {2'b0, cmd.row[0], cmd.slot[0]} :
                      (k_reg == 2'd2) ? {2'b0, cmd.row[1:0], cmd.slot[1:0]} :
                                        {cmd.row, cmd.slot};

    // plain reads keep the word's address until the data is captured
    logic [AW-1:0] rd_addr;
    assign rd_addr = (word_reg.operation == OP_APPLY) ? tgt_addr(cmd.slot) :
                                                        AW'(word_reg.index);

    amp_t m_re, m_im, a_re, a_im;
    assign m_re = mat_rd_reg[2*AMP_WIDTH-1:AMP_WIDTH];
    assign m_im = mat_rd_reg[AMP_WIDTH-1:0];
    assign a_re = gre_reg[cmd.slot];
    assign a_im = gim_reg[cmd.slot];

    amp_t new_re;
    assign new_re = sat_w((SW+1)'(acc_r0_reg) - (SW+1)'(acc_r1_reg));

    // memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.simple && word_reg.operation == OP_WRITE_AMP)
            amp_mem[AW'(word_reg.index)] <= {in_sat(word_reg.value_real),
                                             in_sat(word_reg.value_imag)};
        else if (cmd.wb)
            amp_mem[tgt_addr(cmd.row)] <= {new_re, acc_i_reg[AMP_WIDTH-1:0]};
        amp_rd_reg <= amp_mem[rd_addr];
        if (cmd.simple && word_reg.operation == OP_WRITE_MAT)
            mat_mem[word_reg.index[5:0]] <= {in_sat(word_reg.value_real),
                                             in_sat(word_reg.value_imag)};
        mat_rd_reg <= mat_mem[mat_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            word_reg <= in_word;
        if (cmd.gather_cap)
        begin
            gre_reg[cmd.slot] <= amp_rd_reg[2*AMP_WIDTH-1:AMP_WIDTH];
            gim_reg[cmd.slot] <= amp_rd_reg[AMP_WIDTH-1:0];
        end
        if (cmd.mac_issue)
        begin
            p_rr_reg <= fx_mul(m_re, a_re);
            p_ii_reg <= fx_mul(m_im, a_im);
            p_ri_reg <= fx_mul(m_re, a_im);
            p_ir_reg <= fx_mul(m_im, a_re);
        end
        if (cmd.simple_cap)
        begin
            rd_re_reg <= amp_rd_reg[2*AMP_WIDTH-1:AMP_WIDTH];
            rd_im_reg <= amp_rd_reg[AMP_WIDTH-1:0];
        end
    end

    // accumulators and decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= 2'd1;
            kk_reg     <= 4'd2;
            err_reg    <= 1'b0;
            base_reg   <= '0;
            acc_r0_reg <= '0;
            acc_r1_reg <= '0;
            acc_i_reg  <= '0;
        end
        else
        begin
            k_reg    <= k_eff;
            kk_reg   <= kk_eff;
            err_reg  <= dec_err;
            base_reg <= base_c;
            if (cmd.acc_clr)
            begin
                acc_r0_reg <= '0;
                acc_r1_reg <= '0;
                acc_i_reg  <= '0;
            end
            else if (cmd.mac_acc)
            begin
                acc_r0_reg <= SW'(sat_w((SW+1)'(acc_r0_reg) + (SW+1)'(p_rr_reg)));
                acc_r1_reg <= SW'(sat_w((SW+1)'(acc_r1_reg) + (SW+1)'(p_ii_reg)));
                acc_i_reg  <= SW'(sat_w((SW+1)'(SW'(sat_w((SW+1)'(acc_i_reg)
                              + (SW+1)'(p_ri_reg)))) + (SW+1)'(p_ir_reg)));
            end
        end
    end

    // the matrix entry for row/slot is fetched in S_ROW or S_ACC, so
    // mat_rd_reg holds it when mac_issue fires in S_MUL
    assign status.is_apply = (word_reg.operation == OP_APPLY);
    assign status.err      = dec_err;
    assign status.kk       = kk_reg;

    assign result.read_real   = (!err_reg && word_reg.operation == OP_READ_AMP) ?
                                out_sat(rd_re_reg) : 16'd0;
    assign result.read_imag   = (!err_reg && word_reg.operation == OP_READ_AMP) ?
                                out_sat(rd_im_reg) : 16'd0;
    assign result.index_error = err_reg;

endmodule

/* hdl/quantum_gate_state_update_unit.sv */
// Channel   Direction  Handshake          Word
// in        input      in_valid/in_stall  operation, index, value_real, value_imag
// out       output     out_valid/out_stall read_real, read_imag, index_error
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
// Writes/reads pass S_DEC, S_SIMPLE, S_SIMPLE_RD, S_SIMPLE_CAP, S_DONE; an error
// skips to S_DONE. Apply gathers the target amplitudes, then multiplies row by row,
// paced by the single shared complex multiply unit and the amplitude memory port.
// Reset initialises control and configuration; memories hold garbage until written.
// The result is valid the cycle after done and waits while out_stall is high; a new
// word is accepted only once the engine is idle and the output register is empty.
`include "quantum_gate_state_update_unit_defines.svh"
module quantum_gate_state_update_unit
    import qgsu_pkg::*;
#(
    parameter int STATE_QUBITS = 10,
    parameter int MAX_TARGETS  = 3,
    parameter int AMP_WIDTH    = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam logic [1:0] MaxKCfg = (MAX_TARGETS > 3) ? 2'd3 : 2'(MAX_TARGETS);

    logic [1:0] target_count_reg;
    logic [3:0] pos0_reg, pos1_reg, pos2_reg;
    logic       out_valid_reg;
    out_word_t  out_reg;
    qg_cmd_t    cmd;
    qg_status_t status;
    out_word_t  result;
    logic       busy, done, in_go;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy || out_valid_reg;
    assign in_go     = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= 2'd1;
            pos0_reg <= 4'd0;
            pos1_reg <= 4'd1;
            pos2_reg <= 4'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET_COUNT: target_count_reg <= cfg_data[1:0];
                REG_TARGET_POS_0: pos0_reg <= cfg_data;
                REG_TARGET_POS_1: pos1_reg <= cfg_data;
                REG_TARGET_POS_2: pos2_reg <= cfg_data;
                default:          pos0_reg <= pos0_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= result;
    end

    qgsu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_go  (in_go),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    qgsu_datapath #(
        .STATE_QUBITS (STATE_QUBITS),
        .AMP_WIDTH    (AMP_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_word      (in_data),
        .target_count (target_count_reg),
        .target_pos_0 (pos0_reg),
        .target_pos_1 (pos1_reg),
        .target_pos_2 (pos2_reg),
        .max_k        (MaxKCfg),
        .cmd          (cmd),
        .status       (status),
        .result       (result)
    );

    `QG_ASSERT_IMP(a_no_accept_busy, rst_n, busy, in_stall)
    `QG_ASSERT_NEXT(a_done_gives_valid, rst_n, done, out_valid)
    `QG_ASSERT_IMP(a_err_no_read, rst_n, out_valid && out_data.index_error,
        out_data.read_real == 16'd0 && out_data.read_imag == 16'd0)

endmodule
